// ===== rtl/core/pdh_pkg.sv =====
package pdh_pkg;

  // Fixed field and register widths
  localparam int COORD_BITS = 24;
  localparam int NUM_BINS   = 64;
  localparam int BIN_W      = 6;
  localparam int CNT_W      = 32;
  localparam int REG_W      = 23;
  localparam int ACT_W      = 7;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths: fold word, magnitude, sum of squares, root
  localparam int FW     = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 3;
  localparam int MAG_W  = FW - 1;
  localparam int SUM_W  = 2 * MAG_W + 2;
  localparam int RT_W   = SUM_W / 2;
  localparam int STEP_W = $clog2(RT_W + 1);
  localparam int FAR_BIT = 30;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BINS = 3'd4;

  localparam logic [REG_W-1:0] BOX_RESET   = 23'd40960;
  localparam logic [REG_W-1:0] WIDTH_RESET = 23'd410;
  localparam logic [ACT_W-1:0] ACT_RESET   = 7'd64;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_DUMP = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
  } in_req_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_count;
    logic             last;
  } out_res_t;

  typedef struct packed {
    logic             upd;
    logic             dump;
    logic [BIN_W-1:0] bin;
  } hist_cmd_t;

  typedef enum logic [1:0] {T_IDLE, T_DIST, T_HIST} top_state_t;

  typedef enum logic [2:0] {
    D_IDLE, D_DIFF, D_FOLD, D_MUL, D_SQRT, D_DIV, D_DONE
  } dist_state_t;

  typedef enum logic [2:0] {
    H_IDLE, H_UPD_RD, H_UPD_WR, H_DMP_RD, H_DMP_OUT, H_DONE
  } hist_state_t;

endpackage

// ===== rtl/core/pair_distance_histogram_unit.sv =====
// Pair distance histogram. Each add request carries two particle positions
// in signed Q12.12; each axis difference is folded once into the periodic
// box, the squared distance is formed, its integer square root is divided
// by bin_width and, when the bin index is below active_bins (capped at
// NUM_BINS), that bin gains 2 (saturating at 2^32-1). An add request produces
// no result: it works one multiplier bit per cycle for each axis square,
// then one root digit and one quotient bit per cycle, then, unless the pair
// is dropped, a read-modify-write of the bin memory.
// A dump request returns every active bin in index order, last set on the
// final one; each bin is read from the memory and then held on the output
// until it is taken. Input is stalled while a request is in progress. The
// histogram is zero after reset.
module pair_distance_histogram_unit import pdh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata
);

  top_state_t state_r, state_nxt;
  logic [REG_W-1:0] box_x_r, box_y_r, box_z_r, bin_width_r;
  logic [ACT_W-1:0] active_bins_r, n_eff;
  logic       accept, dist_start, dist_done, dist_keep, hist_done, in_range;
  logic [RT_W-1:0] quot;
  hist_cmd_t  cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r       <= BOX_RESET;
      box_y_r       <= BOX_RESET;
      box_z_r       <= BOX_RESET;
      bin_width_r   <= WIDTH_RESET;
      active_bins_r <= ACT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BOX_X:       box_x_r       <= cfg_wdata;
        CFG_BOX_Y:       box_y_r       <= cfg_wdata;
        CFG_BOX_Z:       box_z_r       <= cfg_wdata;
        CFG_BIN_WIDTH:   bin_width_r   <= cfg_wdata;
        CFG_ACTIVE_BINS: active_bins_r <= cfg_wdata[ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign n_eff = (active_bins_r > ACT_W'(NUM_BINS)) ? ACT_W'(NUM_BINS) : active_bins_r;

  assign in_stall = (state_r != T_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = ((quot >> ACT_W) == '0) && (quot[ACT_W-1:0] < n_eff);

  // Sequence one request at a time
  always_comb begin
    state_nxt  = state_r;
    dist_start = 1'b0;
    cmd.upd    = 1'b0;
    cmd.dump   = 1'b0;
    cmd.bin    = quot[BIN_W-1:0];
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_DUMP) begin
            cmd.dump  = 1'b1;
            state_nxt = T_HIST;
          end else begin
            dist_start = 1'b1;
            state_nxt  = T_DIST;
          end
        end
      end
      T_DIST: begin
        if (dist_done) begin
          if (dist_keep && in_range) begin
            cmd.upd   = 1'b1;
            state_nxt = T_HIST;
          end else begin
            state_nxt = T_IDLE;
          end
        end
      end
      T_HIST:  if (hist_done) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  pdh_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dist_start),
    .req       (in_data),
    .box_x     (box_x_r),
    .box_y     (box_y_r),
    .box_z     (box_z_r),
    .bin_width (bin_width_r),
    .done      (dist_done),
    .keep      (dist_keep),
    .quot      (quot)
  );

  pdh_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .n_eff     (n_eff),
    .done      (hist_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/pdh_dist.sv =====
module pdh_dist import pdh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_req_t           req,
  input  logic [REG_W-1:0]  box_x,
  input  logic [REG_W-1:0]  box_y,
  input  logic [REG_W-1:0]  box_z,
  input  logic [REG_W-1:0]  bin_width,
  output logic              done,
  output logic              keep,
  output logic [RT_W-1:0]   quot
);

  dist_state_t state_r, state_nxt;
  in_req_t     req_r;
  logic [1:0]  axis_r;
  logic [STEP_W-1:0] step_r;
  logic signed [FW-1:0] diff_r;
  logic [MAG_W-1:0] mplier_r;
  logic [SUM_W-1:0] mcand_r, sum_r, val_r;
  logic [RT_W+1:0]  rem_r;
  logic [RT_W-1:0]  root_r;
  logic [REG_W-1:0] drem_r;
  logic             far_r;

  logic signed [COORD_BITS-1:0] a_sel, b_sel;
  logic [REG_W-1:0]     box_sel;
  logic signed [FW-1:0] b_s, d2_s, fold_s, abs_s;
  logic [MAG_W-1:0]     mag;
  logic [RT_W+1:0]      rem_sh, trial;
  logic [REG_W:0]       dt;
  logic [REG_W-1:0]     w;

  // Pick the axis under work
  always_comb begin
    case (axis_r)
      2'd0: begin
        a_sel = req_r.first_x; b_sel = req_r.second_x; box_sel = box_x;
      end
      2'd1: begin
        a_sel = req_r.first_y; b_sel = req_r.second_y; box_sel = box_y;
      end
      default: begin
        a_sel = req_r.first_z; b_sel = req_r.second_z; box_sel = box_z;
      end
    endcase
  end

  // Fold the difference once into the box and take its magnitude
  always_comb begin
    b_s  = $signed({{(FW-REG_W){1'b0}}, box_sel});
    d2_s = diff_r <<< 1;
    if (d2_s > b_s) begin
      fold_s = b_s - diff_r;
    end else if (d2_s < -b_s) begin
      fold_s = b_s + diff_r;
    end else begin
      fold_s = diff_r;
    end
    abs_s = (fold_s < 0) ? -fold_s : fold_s;
    mag   = abs_s[MAG_W-1:0];
  end

  // One root digit and one quotient bit per step
  assign rem_sh = {rem_r[RT_W-1:0], val_r[SUM_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign w      = (bin_width == '0) ? REG_W'(1) : bin_width;
  assign dt     = {drem_r, root_r[RT_W-1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE:  if (start) state_nxt = D_DIFF;
      D_DIFF:  state_nxt = D_FOLD;
      D_FOLD:  state_nxt = D_MUL;
      D_MUL: begin
        if (step_r == STEP_W'(MAG_W - 1)) begin
          state_nxt = (axis_r == 2'd2) ? D_SQRT : D_DIFF;
        end
      end
      D_SQRT:  if (step_r == STEP_W'(RT_W - 1)) state_nxt = D_DIV;
      D_DIV:   if (step_r == STEP_W'(RT_W - 1)) state_nxt = D_DONE;
      D_DONE:  state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: serial multiply, restoring root, restoring divide
  always_ff @(posedge clk) begin
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          req_r  <= req;
          axis_r <= 2'd0;
          sum_r  <= '0;
          far_r  <= 1'b0;
        end
      end
      D_DIFF: begin
        diff_r <= FW'(a_sel) - FW'(b_sel);
      end
      D_FOLD: begin
        mplier_r <= mag;
        mcand_r  <= SUM_W'(mag);
        step_r   <= '0;
        if ((mag >> FAR_BIT) != '0) far_r <= 1'b1;
      end
      D_MUL: begin
        if (mplier_r[0]) sum_r <= sum_r + mcand_r;
        mplier_r <= mplier_r >> 1;
        mcand_r  <= mcand_r << 1;
        if (step_r == STEP_W'(MAG_W - 1)) begin
          axis_r <= axis_r + 2'd1;
          step_r <= '0;
          val_r  <= (mplier_r[0]) ? sum_r + mcand_r : sum_r;
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          step_r <= step_r + STEP_W'(1);
        end
      end
      D_SQRT: begin
        val_r  <= val_r << 2;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[RT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[RT_W-2:0], 1'b0};
        end
        if (step_r == STEP_W'(RT_W - 1)) begin
          step_r <= '0;
          drem_r <= '0;
        end else begin
          step_r <= step_r + STEP_W'(1);
        end
      end
      D_DIV: begin
        step_r <= step_r + STEP_W'(1);
        if (dt >= {1'b0, w}) begin
          drem_r <= REG_W'(dt - {1'b0, w});
          root_r <= {root_r[RT_W-2:0], 1'b1};
        end else begin
          drem_r <= dt[REG_W-1:0];
          root_r <= {root_r[RT_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == D_DONE);
  assign keep = !far_r;
  assign quot = root_r;

endmodule

// ===== rtl/core/pdh_hist.sv =====
module pdh_hist import pdh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  hist_cmd_t        cmd,
  input  logic [ACT_W-1:0] n_eff,
  output logic             done,
  output logic             out_valid,
  input  logic             out_stall,
  output out_res_t         out_data
);

  hist_state_t state_r, state_nxt;
  logic [BIN_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  logic [CNT_W-1:0] rd_data_r, cur, upd_val;
  logic             rd_vld_r, last, wr_en;

  // Registered read port; an entry never written reads as zero
  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr_r];
    rd_vld_r  <= vld_r[addr_r];
  end

  assign cur     = rd_vld_r ? rd_data_r : '0;
  assign upd_val = (cur >= CNT_MAX - CNT_W'(1)) ? CNT_MAX : cur + CNT_W'(2);
  assign wr_en   = (state_r == H_UPD_WR);
  assign last    = ({1'b0, addr_r} == n_eff - ACT_W'(1));

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_r] <= upd_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      H_IDLE: begin
        if (cmd.upd) begin
          addr_nxt  = cmd.bin;
          state_nxt = H_UPD_RD;
        end else if (cmd.dump) begin
          addr_nxt  = '0;
          state_nxt = (n_eff == '0) ? H_DONE : H_DMP_RD;
        end
      end
      H_UPD_RD:  state_nxt = H_UPD_WR;
      H_UPD_WR:  state_nxt = H_DONE;
      H_DMP_RD:  state_nxt = H_DMP_OUT;
      H_DMP_OUT: begin
        if (!out_stall) begin
          if (last) begin
            state_nxt = H_DONE;
          end else begin
            addr_nxt  = addr_r + BIN_W'(1);
            state_nxt = H_DMP_RD;
          end
        end
      end
      H_DONE:  state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // Hold the bin on the output until it is taken
  assign out_valid          = (state_r == H_DMP_OUT);
  assign out_data.bin_index = addr_r;
  assign out_data.bin_count = cur;
  assign out_data.last      = last;
  assign done               = (state_r == H_DONE);

`ifndef SYNTHESIS
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.upd && cmd.dump)) else $error("update and dump requested together");
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd || cmd.dump) |-> (state_r == H_IDLE)) else $error("request while busy");
  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.bin_index} < n_eff)) else $error("bin beyond active");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=> (state_r == H_DONE))
    else $error("dump did not end after last bin");
`endif

endmodule
